// ===== design/mpp_pkg.sv =====
// Shared constants, request decode codes and structs of the migration pattern profiler.
// Used by both channel interfaces and by every module but mpp_ram; depends on nothing.
package mpp_pkg;

    localparam int CPU_W     = 3;
    localparam int NUM_CPUS  = 2 ** CPU_W;
    localparam int CELL_AW   = 2 * CPU_W;
    localparam int BIN_W     = 4;
    localparam int HOLD_BINS = 2 ** BIN_W;
    localparam int TASK_W    = 22;
    localparam int MODE_W    = 2;
    localparam int CNT_W     = 32;

    localparam logic [MODE_W-1:0] MODE_RECORD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ_CELL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_BIN  = 2'd2;

    // Memory work that one request carries into the update stage.
    typedef struct packed {
        logic               mat_wr;
        logic [CELL_AW-1:0] mat_addr;
        logic [CNT_W-1:0]   mat_amt;
        logic               hist_wr;
        logic [BIN_W-1:0]   hist_addr;
        logic               rd_cell;
        logic               rd_bin;
        logic [CNT_W-1:0]   records;
    } t_mem_op;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] addr;
        logic [CNT_W-1:0]   data;
    } t_cell_wr;

    typedef struct packed {
        logic             en;
        logic [BIN_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } t_bin_wr;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== design/mpp_req_if.sv =====
// Request channel of the migration pattern profiler: valid/ready plus payload.
// Depends on mpp_pkg for field widths.
interface mpp_req_if;
    logic                         valid;
    logic                         ready;
    logic [mpp_pkg::MODE_W-1:0]   mode;
    logic [mpp_pkg::TASK_W-1:0]   task_id;
    logic [mpp_pkg::CPU_W-1:0]    from_cpu;
    logic [mpp_pkg::CPU_W-1:0]    to_cpu;
    logic [mpp_pkg::BIN_W-1:0]    bin_index;

    modport source (output valid, mode, task_id, from_cpu, to_cpu, bin_index, input ready);
    modport sink   (input valid, mode, task_id, from_cpu, to_cpu, bin_index, output ready);
endinterface

// ===== design/mpp_rsp_if.sv =====
// Result channel of the migration pattern profiler: valid/ready plus payload.
// Depends on mpp_pkg for field widths.
interface mpp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mpp_pkg::CNT_W-1:0]   count_value;
    logic [mpp_pkg::CNT_W-1:0]   records_seen;

    modport source (output valid, count_value, records_seen, input ready);
    modport sink   (input valid, count_value, records_seen, output ready);
endinterface

// ===== design/mpp_ram.sv =====
// Generic single-write, single-read synchronous RAM with per-entry valid bits.
// An entry never written since reset reads as zero. No package dependency.
module mpp_ram #(
    parameter int AW = 4,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);
    localparam int DEPTH = 2 ** AW;

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;
endmodule

// ===== design/mpp_track.sv =====
// Run tracker: compares each record with the previous one, keeps the open runs
// and the record total, and emits the memory work of each request. Uses mpp_pkg.
module mpp_track (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [mpp_pkg::MODE_W-1:0]  i_mode,
    input  logic [mpp_pkg::TASK_W-1:0]  i_task_id,
    input  logic [mpp_pkg::CPU_W-1:0]   i_from_cpu,
    input  logic [mpp_pkg::CPU_W-1:0]   i_to_cpu,
    input  logic [mpp_pkg::BIN_W-1:0]   i_bin_index,
    output mpp_pkg::t_mem_op            o_op
);
    logic [mpp_pkg::TASK_W-1:0] r_prev_task, n_prev_task;
    logic [mpp_pkg::CPU_W-1:0]  r_prev_from, n_prev_from;
    logic [mpp_pkg::CPU_W-1:0]  r_prev_to,   n_prev_to;
    logic                       r_prev_valid, n_prev_valid;
    logic [mpp_pkg::CNT_W-1:0]  r_pp_run, n_pp_run;
    logic [mpp_pkg::CPU_W-1:0]  r_pp_row, n_pp_row;
    logic [mpp_pkg::CPU_W-1:0]  r_pp_col, n_pp_col;
    logic [mpp_pkg::CNT_W-1:0]  r_ho_run, n_ho_run;
    logic [mpp_pkg::CNT_W-1:0]  r_total, n_total;
    logic                       same_task;
    logic                       reverse;

    assign same_task = r_prev_valid && (i_task_id == r_prev_task);
    assign reverse   = (r_prev_from == i_to_cpu) && (r_prev_to == i_from_cpu);

    always_comb begin
        n_prev_task  = r_prev_task;
        n_prev_from  = r_prev_from;
        n_prev_to    = r_prev_to;
        n_prev_valid = r_prev_valid;
        n_pp_run     = r_pp_run;
        n_pp_row     = r_pp_row;
        n_pp_col     = r_pp_col;
        n_ho_run     = r_ho_run;
        n_total      = r_total;
        o_op         = '0;
        case (i_mode)
            mpp_pkg::MODE_RECORD: begin
                if (same_task) begin
                    if (reverse) begin
                        if (r_pp_run == '0) begin
                            n_pp_row = r_prev_from;
                            n_pp_col = r_prev_to;
                        end
                        n_pp_run = mpp_pkg::sat_add(r_pp_run, mpp_pkg::CNT_W'(1));
                    end else begin
                        n_ho_run = mpp_pkg::sat_add(r_ho_run, mpp_pkg::CNT_W'(1));
                    end
                end else begin
                    // flush open runs on a change of task
                    o_op.mat_wr   = (r_pp_run != '0);
                    o_op.mat_addr = {r_pp_row, r_pp_col};
                    o_op.mat_amt  = r_pp_run;
                    o_op.hist_wr  = (r_ho_run != '0);
                    if (r_ho_run > mpp_pkg::CNT_W'(mpp_pkg::HOLD_BINS)) begin
                        o_op.hist_addr = mpp_pkg::BIN_W'(mpp_pkg::HOLD_BINS - 1);
                    end else begin
                        o_op.hist_addr = mpp_pkg::BIN_W'(r_ho_run - mpp_pkg::CNT_W'(1));
                    end
                    n_pp_run = '0;
                    n_ho_run = '0;
                end
                n_prev_task  = i_task_id;
                n_prev_from  = i_from_cpu;
                n_prev_to    = i_to_cpu;
                n_prev_valid = 1'b1;
                n_total      = mpp_pkg::sat_add(r_total, mpp_pkg::CNT_W'(1));
            end
            mpp_pkg::MODE_READ_CELL: begin
                o_op.rd_cell  = 1'b1;
                o_op.mat_addr = {i_from_cpu, i_to_cpu};
            end
            mpp_pkg::MODE_READ_BIN: begin
                o_op.rd_bin    = 1'b1;
                o_op.hist_addr = i_bin_index;
            end
            default: begin
            end
        endcase
        o_op.records = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_task  <= '0;
            r_prev_from  <= '0;
            r_prev_to    <= '0;
            r_prev_valid <= 1'b0;
            r_pp_run     <= '0;
            r_pp_row     <= '0;
            r_pp_col     <= '0;
            r_ho_run     <= '0;
            r_total      <= '0;
        end else if (i_take) begin
            r_prev_task  <= n_prev_task;
            r_prev_from  <= n_prev_from;
            r_prev_to    <= n_prev_to;
            r_prev_valid <= n_prev_valid;
            r_pp_run     <= n_pp_run;
            r_pp_row     <= n_pp_row;
            r_pp_col     <= n_pp_col;
            r_ho_run     <= n_ho_run;
            r_total      <= n_total;
        end
    end

    a_flush_clears_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && (i_mode == mpp_pkg::MODE_RECORD) && !same_task
        |=> (r_pp_run == '0) && (r_ho_run == '0))
        else $error("runs not cleared after change of task");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op.mat_wr |-> (o_op.mat_amt != '0) && (i_mode == mpp_pkg::MODE_RECORD))
        else $error("empty ping-pong run flushed");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |=> (r_total >= $past(r_total)))
        else $error("record total went backwards");
endmodule

// ===== design/mpp_update.sv =====
// Update stage: takes the registered memory reads, forwards the previous write-back
// to the same entry, adds and writes back, and forms the result. Uses mpp_pkg.
module mpp_update (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_take,
    input  mpp_pkg::t_mem_op           i_op,
    input  logic [mpp_pkg::CNT_W-1:0]  i_cell_rdata,
    input  logic [mpp_pkg::CNT_W-1:0]  i_bin_rdata,
    output mpp_pkg::t_cell_wr          o_cell_wr,
    output mpp_pkg::t_bin_wr           o_bin_wr,
    output logic                       o_vld,
    output logic [mpp_pkg::CNT_W-1:0]  o_count_value,
    output logic [mpp_pkg::CNT_W-1:0]  o_records
);
    logic                       r_vld;
    mpp_pkg::t_mem_op           r_op;
    logic                       r_cell_fwd;
    logic [mpp_pkg::CNT_W-1:0]  r_cell_fwd_data;
    logic                       r_bin_fwd;
    logic [mpp_pkg::CNT_W-1:0]  r_bin_fwd_data;
    logic [mpp_pkg::CNT_W-1:0]  cell_cur;
    logic [mpp_pkg::CNT_W-1:0]  bin_cur;
    logic                       cell_rd_new;
    logic                       bin_rd_new;

    assign cell_cur = r_cell_fwd ? r_cell_fwd_data : i_cell_rdata;
    assign bin_cur  = r_bin_fwd  ? r_bin_fwd_data  : i_bin_rdata;

    assign o_cell_wr.en   = i_adv && r_vld && r_op.mat_wr;
    assign o_cell_wr.addr = r_op.mat_addr;
    assign o_cell_wr.data = mpp_pkg::sat_add(cell_cur, r_op.mat_amt);
    assign o_bin_wr.en    = i_adv && r_vld && r_op.hist_wr;
    assign o_bin_wr.addr  = r_op.hist_addr;
    assign o_bin_wr.data  = mpp_pkg::sat_add(bin_cur, mpp_pkg::CNT_W'(1));

    assign cell_rd_new = i_take && (i_op.mat_wr || i_op.rd_cell);
    assign bin_rd_new  = i_take && (i_op.hist_wr || i_op.rd_bin);

    assign o_vld         = r_vld;
    assign o_records     = r_op.records;
    assign o_count_value = r_op.rd_cell ? cell_cur :
                           r_op.rd_bin  ? bin_cur  : '0;

    always_ff @(posedge i_clk) begin
        if (i_adv && i_take) begin
            r_op <= i_op;
        end
        if (i_adv) begin
            r_cell_fwd_data <= o_cell_wr.data;
            r_bin_fwd_data  <= o_bin_wr.data;
        end
    end

    // forward a write-back that lands in the same cycle as the read of that entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_cell_fwd <= 1'b0;
            r_bin_fwd  <= 1'b0;
        end else if (i_adv) begin
            r_vld      <= i_take;
            r_cell_fwd <= o_cell_wr.en && cell_rd_new && (i_op.mat_addr == r_op.mat_addr);
            r_bin_fwd  <= o_bin_wr.en && bin_rd_new && (i_op.hist_addr == r_op.hist_addr);
        end
    end

    a_fwd_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cell_fwd || r_bin_fwd) |-> r_vld)
        else $error("forwarded data without a request in the update stage");

    a_op_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> !((r_op.mat_wr || r_op.hist_wr) && (r_op.rd_cell || r_op.rd_bin)))
        else $error("request both reads and updates counts");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_adv |=> r_vld && $stable(r_op))
        else $error("update stage lost a stalled request");
endmodule

// ===== design/migration_pattern_profiler_core.sv =====
// Top level of the migration pattern profiler: tracker, two count memories,
// update stage and output register. Uses mpp_pkg, mpp_req_if and mpp_rsp_if.
//
// One result per request, in order. A request is taken every cycle while the output
// register is empty or being drained. Its result passes the update stage register and
// then the output register before it shows on the output.
// Each request does at most one read-modify-write in the 64-cell ping-pong memory and
// one in the 16-bin hand-off memory. The read is issued at acceptance. The write-back
// happens when the request leaves the update stage, which a waiting result delays
// while it stalls the pipe. The write-back is forwarded when the next request reads
// the same entry, so each memory, with one read and one write port, keeps up a rate
// of one request per cycle while the pipe is not stalled.
// Reset clears all counts at once through per-entry valid bits; no clearing pass.
module migration_pattern_profiler_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mpp_req_if.sink        i_req,
    mpp_rsp_if.source      o_rsp
);
    logic                       adv;
    logic                       take;
    mpp_pkg::t_mem_op           op;
    mpp_pkg::t_cell_wr          cell_wr;
    mpp_pkg::t_bin_wr           bin_wr;
    logic [mpp_pkg::CNT_W-1:0]  cell_rdata;
    logic [mpp_pkg::CNT_W-1:0]  bin_rdata;
    logic                       upd_vld;
    logic [mpp_pkg::CNT_W-1:0]  upd_value;
    logic [mpp_pkg::CNT_W-1:0]  upd_records;
    logic                       r_out_vld;
    logic [mpp_pkg::CNT_W-1:0]  r_out_value;
    logic [mpp_pkg::CNT_W-1:0]  r_out_records;

    // advance the whole pipe unless a result is waiting and not taken
    assign adv         = !r_out_vld || o_rsp.ready;
    assign take        = i_req.valid && adv;
    assign i_req.ready = adv;

    mpp_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_mode      (i_req.mode),
        .i_task_id   (i_req.task_id),
        .i_from_cpu  (i_req.from_cpu),
        .i_to_cpu    (i_req.to_cpu),
        .i_bin_index (i_req.bin_index),
        .o_op        (op)
    );

    mpp_ram #(.AW(mpp_pkg::CELL_AW), .DW(mpp_pkg::CNT_W)) u_cell_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (take && (op.mat_wr || op.rd_cell)),
        .i_rd_addr (op.mat_addr),
        .o_rd_data (cell_rdata),
        .i_wr_en   (cell_wr.en),
        .i_wr_addr (cell_wr.addr),
        .i_wr_data (cell_wr.data)
    );

    mpp_ram #(.AW(mpp_pkg::BIN_W), .DW(mpp_pkg::CNT_W)) u_bin_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (take && (op.hist_wr || op.rd_bin)),
        .i_rd_addr (op.hist_addr),
        .o_rd_data (bin_rdata),
        .i_wr_en   (bin_wr.en),
        .i_wr_addr (bin_wr.addr),
        .i_wr_data (bin_wr.data)
    );

    mpp_update u_update (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_take        (take),
        .i_op          (op),
        .i_cell_rdata  (cell_rdata),
        .i_bin_rdata   (bin_rdata),
        .o_cell_wr     (cell_wr),
        .o_bin_wr      (bin_wr),
        .o_vld         (upd_vld),
        .o_count_value (upd_value),
        .o_records     (upd_records)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_value   <= upd_value;
            r_out_records <= upd_records;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= upd_vld;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.count_value  = r_out_value;
    assign o_rsp.records_seen = r_out_records;

    a_no_write_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |-> !cell_wr.en && !bin_wr.en)
        else $error("count memory written while the pipe is stalled");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && upd_vld |=> r_out_vld)
        else $error("update stage result dropped");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_rsp.ready |=> r_out_vld && $stable(r_out_value)
        && $stable(r_out_records))
        else $error("waiting result changed");
endmodule
